FILE: hw/rtl/bnsl_pkg.sv
// Shared types and constants for the negative-slope line rasteriser.
`default_nettype none
package bnsl_pkg;

  localparam int COORD_BITS = 12;
  localparam int COLOR_BITS = 24;
  // error term: twice a delta plus sign, with one bit of headroom
  localparam int ERR_BITS   = COORD_BITS + 3;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef struct packed {
    logic   command;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t color;
  } line_cmd_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   is_last;
    logic   direction_error;
  } pixel_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bresenham_negative_slope_line_core.sv
// A pixel appears in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle while out_ready holds; the step logic sits between the line state and
// the output register, and input ready follows the output register being free or being taken.
// An advance item with no line in progress is taken and gives no pixel.
// Reset (rst_n low, synchronous) empties the output register and marks no line loaded.
`default_nettype none
module bresenham_negative_slope_line_core
  import bnsl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire line_cmd_t in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output pixel_t         out_data
);

  coord_t cur_x_r, cur_x_nxt;
  coord_t cur_y_r, cur_y_nxt;
  coord_t stop_x_r, stop_x_nxt;
  coord_t stop_y_r, stop_y_nxt;
  coord_t delta_x_r, delta_x_nxt;
  coord_t delta_y_r, delta_y_nxt;
  err_t   error_r, error_nxt;
  logic   y_major_r, y_major_nxt;
  color_t color_r, color_nxt;
  logic   finished_r, finished_nxt;

  logic   out_valid_r, out_valid_nxt;
  pixel_t out_data_r, out_data_nxt;

  logic   in_acc;
  logic   emit;
  logic   bad_dir;
  coord_t ld_dx, ld_dy;
  err_t   dx_e, dy_e, ld_dx_e, ld_dy_e;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign bad_dir = (in_data.end_x > in_data.start_x) || (in_data.end_y < in_data.start_y);
  assign ld_dx   = in_data.start_x - in_data.end_x;
  assign ld_dy   = in_data.end_y - in_data.start_y;
  assign ld_dx_e = err_t'({3'b000, ld_dx});
  assign ld_dy_e = err_t'({3'b000, ld_dy});
  assign dx_e    = err_t'({3'b000, delta_x_r});
  assign dy_e    = err_t'({3'b000, delta_y_r});

  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    stop_x_nxt    = stop_x_r;
    stop_y_nxt    = stop_y_r;
    delta_x_nxt   = delta_x_r;
    delta_y_nxt   = delta_y_r;
    error_nxt     = error_r;
    y_major_nxt   = y_major_r;
    color_nxt     = color_r;
    finished_nxt  = finished_r;
    emit          = 1'b0;
    out_data_nxt  = out_data_r;

    if (in_acc) begin
      if (in_data.command == CMD_LOAD) begin
        emit       = 1'b1;
        cur_x_nxt  = in_data.start_x;
        cur_y_nxt  = in_data.start_y;
        stop_x_nxt = in_data.end_x;
        stop_y_nxt = in_data.end_y;
        color_nxt  = in_data.color;
        if (bad_dir) begin
          delta_x_nxt  = '0;
          delta_y_nxt  = '0;
          error_nxt    = '0;
          y_major_nxt  = 1'b0;
          finished_nxt = 1'b1;
        end else begin
          delta_x_nxt  = ld_dx;
          delta_y_nxt  = ld_dy;
          y_major_nxt  = ld_dx < ld_dy;
          if (ld_dx < ld_dy) begin
            error_nxt = (ld_dx_e <<< 1) - ld_dy_e;
          end else begin
            error_nxt = (ld_dy_e <<< 1) - ld_dx_e;
          end
          finished_nxt = (in_data.start_x == in_data.end_x)
                      && (in_data.start_y == in_data.end_y);
        end
        out_data_nxt.direction_error = bad_dir;
      end else if (!finished_r) begin
        emit = 1'b1;
        if (!error_r[ERR_BITS-1]) begin
          // diagonal step
          cur_x_nxt = cur_x_r - coord_t'(1);
          cur_y_nxt = cur_y_r + coord_t'(1);
          if (y_major_r) begin
            error_nxt = error_r + (dx_e <<< 1) - (dy_e <<< 1);
          end else begin
            error_nxt = error_r + (dy_e <<< 1) - (dx_e <<< 1);
          end
        end else if (y_major_r) begin
          cur_y_nxt = cur_y_r + coord_t'(1);
          error_nxt = error_r + (dx_e <<< 1);
        end else begin
          cur_x_nxt = cur_x_r - coord_t'(1);
          error_nxt = error_r + (dy_e <<< 1);
        end
        finished_nxt = (cur_x_nxt == stop_x_r) && (cur_y_nxt == stop_y_r);
        out_data_nxt.direction_error = 1'b0;
      end
    end

    if (emit) begin
      out_data_nxt.pixel_x     = cur_x_nxt;
      out_data_nxt.pixel_y     = cur_y_nxt;
      out_data_nxt.pixel_color = color_nxt;
      out_data_nxt.is_last     = finished_nxt;
    end

    // hold a waiting pixel, drop it once taken
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      finished_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    stop_x_r   <= stop_x_nxt;
    stop_y_r   <= stop_y_nxt;
    delta_x_r  <= delta_x_nxt;
    delta_y_r  <= delta_y_nxt;
    error_r    <= error_nxt;
    y_major_r  <= y_major_nxt;
    color_r    <= color_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.direction_error |-> out_data_r.is_last)
    else $error("direction error on a pixel not marked last");

  a_idle_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.command == CMD_ADVANCE && finished_r |=> !out_valid_r)
    else $error("pixel produced by advance with no line");

  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.command == CMD_LOAD |=>
      out_valid_r && out_data_r.pixel_x == $past(in_data.start_x)
      && out_data_r.pixel_y == $past(in_data.start_y))
    else $error("load did not emit its start pixel");

  a_last_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !(in_data.command == CMD_ADVANCE && finished_r) |=>
      out_valid_r && finished_r == out_data_r.is_last)
    else $error("last flag disagrees with line state");
`endif

endmodule
`default_nettype wire
